### hdl/bdae_pkg.sv
// ----------------------------------------------------------------------------
// bdae_pkg - binary to decimal ASCII emitter package
// Sizes, codes and control types shared by the emitter and its conversion core.
// ----------------------------------------------------------------------------
package bdae_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int MAX_DIGITS   = 10;
	localparam int BCD_BITS     = 4 * MAX_DIGITS;
	localparam int BIT_CNT_BITS = $clog2(VALUE_BITS + 1);
	localparam int DIG_CNT_BITS = $clog2(MAX_DIGITS + 1);

	localparam logic [5:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic load;
		logic conv;
		logic shift;
	} dab_ctl_t;

	typedef struct packed {
		logic [3:0] top_digit;
		logic       ovf;
	} dab_sts_t;

endpackage

### hdl/bdae_dabble_core.sv
// ----------------------------------------------------------------------------
// bdae_dabble_core - shift-add-3 conversion core
// Holds the binary and BCD words; one add-3/shift step per conv cycle, then
// shifts BCD digits out from the top one per shift cycle.
// ----------------------------------------------------------------------------
module bdae_dabble_core (
	input  logic                clk,
	input  logic                arst_n,
	input  bdae_pkg::dab_ctl_t  ctl,
	input  logic [31:0]         value,
	output bdae_pkg::dab_sts_t  sts
);

	logic [bdae_pkg::VALUE_BITS-1:0] bin_q;
	logic [bdae_pkg::BCD_BITS-1:0]   bcd_q;
	logic [bdae_pkg::BCD_BITS-1:0]   adj;
	logic                            ovf_q;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < bdae_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= bdae_pkg::VALUE_BITS'(value);
			bcd_q <= '0;
		end else if (ctl.conv) begin
			bin_q <= {bin_q[bdae_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[bdae_pkg::BCD_BITS-2:0], bin_q[bdae_pkg::VALUE_BITS-1]};
		end else if (ctl.shift) begin
			bcd_q <= {bcd_q[bdae_pkg::BCD_BITS-5:0], 4'b0000};
		end
	end

	// sticky: a carry out of the top digit means the value was truncated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctl.load) begin
			ovf_q <= 1'b0;
		end else if (ctl.conv && adj[bdae_pkg::BCD_BITS-1]) begin
			ovf_q <= 1'b1;
		end
	end

	assign sts.top_digit = bcd_q[bdae_pkg::BCD_BITS-1 -: 4];
	assign sts.ovf       = ovf_q;

endmodule

### hdl/binary_to_decimal_ascii_emitter_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter_unit - decimal ASCII digit emitter
// Converts an unsigned binary word to ASCII decimal digits, MSD first.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The conversion core
// then runs one shift-add-3 step per cycle, one for each of the VALUE_BITS
// (32) input bits, after which the sequencer walks the MAX_DIGITS (10) BCD
// digits from the top, one per cycle: leading zeros are dropped silently,
// every other digit is put on digit_char with strobe high for exactly one
// cycle, and last_digit marks the final one. The last word is on the ports
// in the same cycle that busy drops. Zero gives a single '0'. The receiver
// cannot stall: each word must be captured while strobe is high.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_emitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        busy,
	output logic        strobe,
	output logic [5:0]  digit_char,
	output logic        last_digit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                        state_q;
	logic [bdae_pkg::BIT_CNT_BITS-1:0] bit_cnt_q;
	logic [bdae_pkg::DIG_CNT_BITS-1:0] dig_cnt_q;
	logic                              started_q;
	logic                              strobe_q;
	logic [5:0]                        digit_char_q;
	logic                              last_digit_q;

	bdae_pkg::dab_ctl_t ctl;
	bdae_pkg::dab_sts_t sts;
	logic               accept;
	logic               is_last;
	logic               emit_now;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_last  = (dig_cnt_q == bdae_pkg::DIG_CNT_BITS'(1));
	assign emit_now = started_q || sts.ovf || (sts.top_digit != 4'd0) || is_last;

	assign ctl.load  = accept;
	assign ctl.conv  = (state_q == ST_CONV);
	assign ctl.shift = (state_q == ST_EMIT);

	bdae_dabble_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.value  (value),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			started_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= bdae_pkg::BIT_CNT_BITS'(bdae_pkg::VALUE_BITS);
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == bdae_pkg::BIT_CNT_BITS'(1)) begin
						state_q   <= ST_EMIT;
						dig_cnt_q <= bdae_pkg::DIG_CNT_BITS'(bdae_pkg::MAX_DIGITS);
					end
				end
				ST_EMIT: begin
					dig_cnt_q <= dig_cnt_q - 1'b1;
					if (emit_now) begin
						strobe_q  <= 1'b1;
						started_q <= 1'b1;
					end
					if (is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_now) begin
			digit_char_q <= bdae_pkg::ASCII_ZERO + {2'b00, sts.top_digit};
			last_digit_q <= is_last;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit_char = digit_char_q;
	assign last_digit = last_digit_q;

`ifndef NO_ASSERTIONS
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_digit |=> !strobe)
		else $error("word after last digit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
		else $error("digit out of range");

	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without work");
`endif

endmodule
